// File: sv/wegs_pkg.sv
// shared types, register codes and constants for the wave grid step unit
package wegs_pkg;

   localparam int U_W        = 16;
   localparam int DU_W       = 24;
   localparam int C_W        = 16;
   localparam int GRAY_W     = 8;
   localparam int CELL_W     = U_W + DU_W + C_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INV_STEP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COURANT_SQ  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DAMPING     = 3'd5;

   // register values after reset
   localparam logic [10:0] RST_GRID_WIDTH  = 11'd256;
   localparam logic [15:0] RST_GRID_HEIGHT = 16'd256;
   localparam logic [15:0] RST_TIME_STEP   = 16'd1092;
   localparam logic [23:0] RST_INV_STEP    = 24'd15360;
   localparam logic [17:0] RST_COURANT_SQ  = 18'd16384;
   localparam logic [16:0] RST_DAMPING     = 17'd65531;

   // gray level of a zero displacement
   localparam logic [GRAY_W-1:0] GRAY_ZERO = 8'd127;

   typedef struct packed {
      logic [15:0] ts;
      logic [23:0] its;
      logic [17:0] cs;
      logic [16:0] damp;
   } cfg_type;

   typedef struct packed {
      logic signed [U_W-1:0]  ul;
      logic signed [U_W-1:0]  ur;
      logic signed [U_W-1:0]  uu;
      logic signed [U_W-1:0]  ud;
      logic signed [U_W-1:0]  uc;
      logic signed [DU_W-1:0] du;
      logic [C_W-1:0]         c;
   } opnd_type;

   typedef struct packed {
      logic signed [U_W-1:0]  u;
      logic signed [DU_W-1:0] du;
      logic [C_W-1:0]         c;
      logic [GRAY_W-1:0]      gray;
   } res_type;

   // 255 * (clamp(u, -0.5, 0.5) + 0.5), u in Q1.14
   function automatic logic [GRAY_W-1:0] gray_of(input logic signed [U_W-1:0] u);
      logic signed [U_W-1:0] uc;
      logic [14:0] g;
      logic [22:0] p;
      if (u > 16'sd8192) begin
         uc = 16'sd8192;
      end else if (u < -16'sd8192) begin
         uc = -16'sd8192;
      end else begin
         uc = u;
      end
      g = 15'(uc + 16'sd8192);
      p = 23'(g) * 23'd255;
      return p[21:14];
   endfunction

endpackage

// File: sv/wegs_line_store.sv
// two-row line store: one write port, one registered read port
module wegs_line_store #(
   parameter int ADDR_W = 11,
   parameter int DATA_W = 56
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [1 << ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/wegs_datapath.sv
// nine-stage fixed-point update of one interior cell
module wegs_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  wegs_pkg::opnd_type  op,
   input  wegs_pkg::cfg_type   cfg,
   output logic                done,
   output wegs_pkg::res_type   res
);

   localparam int STAGES = 9;

   function automatic logic signed [32:0] clamp33(input logic signed [39:0] v);
      if (v > 40'sd4294967295) begin
         return 33'sh0FFFFFFFF;
      end else if (v < -40'sd4294967296) begin
         return 33'sh100000000;
      end else begin
         return v[32:0];
      end
   endfunction

   logic [STAGES-1:0] vld_ff, vld_in;

   // stage 1
   logic signed [40:0] p_dt_ff, p_dt_in;
   logic [31:0]        csq_ff, csq_in;
   logic signed [18:0] lap_ff, lap_in;
   logic signed [15:0] uc_ff;
   logic [15:0]        c_ff;
   // stage 2
   logic signed [24:0] dtdu_ff, dtdu_in;
   logic [49:0]        pa_ff, pa_in;
   logic signed [18:0] lap2_ff;
   logic signed [15:0] uc2_ff;
   logic [15:0]        c2_ff;
   // stage 3
   logic [33:0]        a2_ff, a2_in;
   logic signed [25:0] ucdt_ff, ucdt_in;
   logic signed [24:0] dtdu3_ff;
   logic signed [18:0] lap3_ff;
   logic [15:0]        c3_ff;
   // stage 4
   logic signed [53:0] p_lt_ff, p_lt_in;
   logic signed [24:0] dtdu4_ff;
   logic signed [25:0] ucdt4_ff;
   logic [15:0]        c4_ff;
   // stage 5
   logic signed [37:0] lt_ff, lt_in;
   logic signed [24:0] dtdu5_ff;
   logic signed [25:0] ucdt5_ff;
   logic [15:0]        c5_ff;
   // stage 6
   logic signed [39:0] diff_w, un_w;
   logic signed [32:0] diff_ff, un_ff;
   logic [15:0]        c6_ff;
   // stage 7
   logic signed [57:0] p_dn_ff, p_dn_in;
   logic signed [50:0] p_uo_ff, p_uo_in;
   logic [15:0]        c7_ff;
   // stage 8
   logic signed [49:0] dn_w;
   logic signed [34:0] uo_w;
   logic signed [23:0] du8_ff, du8_in;
   logic signed [15:0] u8_ff, u8_in;
   logic [15:0]        c8_ff;
   // stage 9
   wegs_pkg::res_type  res_ff;

   always_comb begin
      vld_in  = {vld_ff[STAGES-2:0], start};
      p_dt_in = $signed(op.du) * $signed({1'b0, cfg.ts});
      csq_in  = op.c * op.c;
      lap_in  = 19'(op.ul) + 19'(op.ur) + 19'(op.uu) + 19'(op.ud) - (19'(op.uc) <<< 2);
      dtdu_in = 25'((p_dt_ff + 41'sd32768) >>> 16);
      pa_in   = 50'(csq_ff) * 50'(cfg.cs);
      a2_in   = 34'((pa_ff + 50'd32768) >> 16);
      ucdt_in = 26'(uc2_ff) + 26'(dtdu_ff);
      p_lt_in = $signed({1'b0, a2_ff}) * lap3_ff;
      lt_in   = 38'((p_lt_ff + 54'sd32768) >>> 16);
      diff_w  = 40'(dtdu5_ff) + 40'(lt_ff);
      un_w    = 40'(ucdt5_ff) + 40'(lt_ff);
      p_dn_in = diff_ff * $signed({1'b0, cfg.its});
      p_uo_in = un_ff * $signed({1'b0, cfg.damp});
      dn_w    = 50'((p_dn_ff + 58'sd128) >>> 8);
      uo_w    = 35'((p_uo_ff + 51'sd32768) >>> 16);
      if (dn_w > 50'sd8388607) begin
         du8_in = 24'sh7FFFFF;
      end else if (dn_w < -50'sd8388608) begin
         du8_in = 24'sh800000;
      end else begin
         du8_in = dn_w[23:0];
      end
      if (uo_w > 35'sd32767) begin
         u8_in = 16'sh7FFF;
      end else if (uo_w < -35'sd32768) begin
         u8_in = 16'sh8000;
      end else begin
         u8_in = uo_w[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      p_dt_ff  <= p_dt_in;
      csq_ff   <= csq_in;
      lap_ff   <= lap_in;
      uc_ff    <= op.uc;
      c_ff     <= op.c;
      dtdu_ff  <= dtdu_in;
      pa_ff    <= pa_in;
      lap2_ff  <= lap_ff;
      uc2_ff   <= uc_ff;
      c2_ff    <= c_ff;
      a2_ff    <= a2_in;
      ucdt_ff  <= ucdt_in;
      dtdu3_ff <= dtdu_ff;
      lap3_ff  <= lap2_ff;
      c3_ff    <= c2_ff;
      p_lt_ff  <= p_lt_in;
      dtdu4_ff <= dtdu3_ff;
      ucdt4_ff <= ucdt_ff;
      c4_ff    <= c3_ff;
      lt_ff    <= lt_in;
      dtdu5_ff <= dtdu4_ff;
      ucdt5_ff <= ucdt4_ff;
      c5_ff    <= c4_ff;
      diff_ff  <= clamp33(diff_w);
      un_ff    <= clamp33(un_w);
      c6_ff    <= c5_ff;
      p_dn_ff  <= p_dn_in;
      p_uo_ff  <= p_uo_in;
      c7_ff    <= c6_ff;
      du8_ff   <= du8_in;
      u8_ff    <= u8_in;
      c8_ff    <= c7_ff;
      if (vld_ff[STAGES-2]) begin
         res_ff.u    <= u8_ff;
         res_ff.du   <= du8_ff;
         res_ff.c    <= c8_ff;
         res_ff.gray <= wegs_pkg::gray_of(u8_ff);
      end
   end

   assign done = vld_ff[STAGES-1];
   assign res  = res_ff;

endmodule

// File: sv/wave_equation_grid_step_unit.sv
// top level: raster counters, line store sequencer, result register
//
// channel | direction | handshake                 | beat
// req_    | in        | req_valid / req_stall     | one grid cell (u, du, c)
// rsp_    | out       | rsp_valid / rsp_stall     | one updated cell, gray, flags
// csr_    | in        | csr_valid / csr_ready     | register index and write data
//
// one cell at a time: an interior cell is accepted, read four times through
// the single read port of the line store, written, started, run through
// nine stages of arithmetic and sent as one result beat, two on the last
// row; first-row cells are only accepted and written, border cells send one
// zero beat, two on the last row. a stalled result holds the last beat and
// the sequencer waits. synchronous reset clears counters and handshake state
// and loads the register reset values; the line store is not cleared.
module wave_equation_grid_step_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // input cells
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [wegs_pkg::U_W-1:0]     req_in_u,
   input  logic signed [wegs_pkg::DU_W-1:0]    req_in_du,
   input  logic [wegs_pkg::C_W-1:0]            req_in_c,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [wegs_pkg::U_W-1:0]     rsp_out_u,
   output logic signed [wegs_pkg::DU_W-1:0]    rsp_out_du,
   output logic [wegs_pkg::C_W-1:0]            rsp_out_c,
   output logic [wegs_pkg::GRAY_W-1:0]         rsp_gray,
   output logic                                rsp_last_of_run,
   output logic                                rsp_last_of_frame,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wegs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wegs_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int AW = XW + 1;
   localparam int CW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
   localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);
   localparam logic [CW-1:0] MINW_C = CW'(3);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_WRITE = 3'd2;
   localparam logic [2:0] ST_START = 3'd3;
   localparam logic [2:0] ST_CALC  = 3'd4;
   localparam logic [2:0] ST_OUT1  = 3'd5;
   localparam logic [2:0] ST_OUT2  = 3'd6;

   // read steps: left, center, right of the previous row, then the row above it
   localparam logic [1:0] RD_LEFT   = 2'd0;
   localparam logic [1:0] RD_CENTER = 2'd1;
   localparam logic [1:0] RD_RIGHT  = 2'd2;
   localparam logic [1:0] RD_UP     = 2'd3;

   // configuration registers
   logic [10:0] gw_ff;
   logic [15:0] gh_ff, ts_ff;
   logic [23:0] its_ff;
   logic [17:0] cs_ff;
   logic [16:0] damp_ff;

   // raster position
   logic [XW-1:0] col_ff, col_in;
   logic [15:0]   row_ff, row_in;
   logic [CW-1:0] gw_ext, w_eff;
   logic [15:0]   h_eff, y_cur;
   logic [XW-1:0] x_cur;
   logic          x_last, last_row, req_take;

   // sequencer
   logic [2:0] state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic       rvalid_ff;
   logic [1:0] rtag_ff;

   // current item
   logic signed [15:0] d_u_ff;
   logic signed [23:0] d_du_ff;
   logic [15:0]        d_c_ff;
   logic [XW-1:0]      x_ff;
   logic               ybit_ff, has_r1_ff, calc_ff, r1_run_ff, has_r2_ff, r2_frame_ff;

   // neighbors from the line store
   logic signed [15:0] ul_ff, ur_ff, uu_ff, uc_ff;
   logic signed [23:0] pdu_ff;
   logic [15:0]        pc_ff;

   // line store ports
   logic                           rd_en, wr_en;
   logic [AW-1:0]                  rd_addr, wr_addr;
   logic [wegs_pkg::CELL_W-1:0]    rd_data, wr_data;

   // datapath
   logic                dp_start, dp_done;
   wegs_pkg::opnd_type  dp_op;
   wegs_pkg::cfg_type   dp_cfg;
   wegs_pkg::res_type   dp_res;

   // result register
   logic                rsp_valid_ff, rsp_valid_in, out_free, out_load;
   wegs_pkg::res_type   out_ff, out_in;
   logic                run_ff, run_in, frame_ff, frame_in;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff   <= wegs_pkg::RST_GRID_WIDTH;
         gh_ff   <= wegs_pkg::RST_GRID_HEIGHT;
         ts_ff   <= wegs_pkg::RST_TIME_STEP;
         its_ff  <= wegs_pkg::RST_INV_STEP;
         cs_ff   <= wegs_pkg::RST_COURANT_SQ;
         damp_ff <= wegs_pkg::RST_DAMPING;
      end else if (csr_valid) begin
         case (csr_index)
            wegs_pkg::REG_GRID_WIDTH:  gw_ff   <= csr_data[10:0];
            wegs_pkg::REG_GRID_HEIGHT: gh_ff   <= csr_data[15:0];
            wegs_pkg::REG_TIME_STEP:   ts_ff   <= csr_data[15:0];
            wegs_pkg::REG_INV_STEP:    its_ff  <= csr_data[23:0];
            wegs_pkg::REG_COURANT_SQ:  cs_ff   <= csr_data[17:0];
            wegs_pkg::REG_DAMPING:     damp_ff <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   // effective grid size and the position of the arriving cell
   always_comb begin
      gw_ext = CW'(gw_ff);
      if (gw_ext < MINW_C) begin
         w_eff = MINW_C;
      end else if (gw_ext > MAXW_C) begin
         w_eff = MAXW_C;
      end else begin
         w_eff = gw_ext;
      end
      h_eff    = (gh_ff < 16'd3) ? 16'd3 : gh_ff;
      // a counter beyond a shrunk size restarts
      x_cur    = (CW'(col_ff) >= w_eff) ? '0 : col_ff;
      y_cur    = (row_ff >= h_eff) ? 16'd0 : row_ff;
      x_last   = (CW'(x_cur) == w_eff - CW'(1));
      last_row = (y_cur == h_eff - 16'd1);
      req_take = req_valid && !req_stall;
      col_in   = col_ff;
      row_in   = row_ff;
      if (req_take) begin
         if (x_last) begin
            col_in = '0;
            row_in = last_row ? 16'd0 : y_cur + 16'd1;
         end else begin
            col_in = x_cur + XW'(1);
            row_in = y_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // latch the cell and what it will produce
   always_ff @(posedge clock) begin
      if (req_take) begin
         d_u_ff      <= req_in_u;
         d_du_ff     <= req_in_du;
         d_c_ff      <= req_in_c;
         x_ff        <= x_cur;
         ybit_ff     <= y_cur[0];
         has_r1_ff   <= (y_cur != 16'd0);
         // interior: not the first two rows, not the first or last column
         calc_ff     <= (y_cur > 16'd1) && (x_cur != '0) && !x_last;
         r1_run_ff   <= !last_row;
         has_r2_ff   <= last_row;
         r2_frame_ff <= x_last;
      end
   end

   // line store access; rows alternate on the low row bit
   always_comb begin
      rd_en   = (state_ff == ST_READ);
      case (step_ff)
         RD_LEFT:   rd_addr = {~ybit_ff, x_ff - XW'(1)};
         RD_CENTER: rd_addr = {~ybit_ff, x_ff};
         RD_RIGHT:  rd_addr = {~ybit_ff, x_ff + XW'(1)};
         RD_UP:     rd_addr = {ybit_ff, x_ff};
         default:   rd_addr = {ybit_ff, x_ff};
      endcase
      // the cell overwrites the row above the previous one, after it was read
      wr_en   = (state_ff == ST_WRITE);
      wr_addr = {ybit_ff, x_ff};
      wr_data = {d_u_ff, d_du_ff, d_c_ff};
   end

   wegs_line_store #(
      .ADDR_W (AW),
      .DATA_W (wegs_pkg::CELL_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read data returns in the cycle after the address, tagged by step
   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rtag_ff <= step_ff;
      if (rvalid_ff) begin
         case (rtag_ff)
            RD_LEFT:   ul_ff <= rd_data[55:40];
            RD_CENTER: begin
               uc_ff  <= rd_data[55:40];
               pdu_ff <= rd_data[39:16];
               pc_ff  <= rd_data[15:0];
            end
            RD_RIGHT:  ur_ff <= rd_data[55:40];
            RD_UP:     uu_ff <= rd_data[55:40];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dp_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               step_in  = RD_LEFT;
               state_in = ((y_cur > 16'd1) && (x_cur != '0) && !x_last) ? ST_READ : ST_WRITE;
            end
         end
         ST_READ: begin
            step_in = step_ff + 2'd1;
            if (step_ff == RD_UP) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (calc_ff) begin
               state_in = ST_START;
            end else if (has_r1_ff) begin
               state_in = ST_OUT1;
            end else if (has_r2_ff) begin
               state_in = ST_OUT2;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_START: begin
            dp_start = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (dp_done) begin
               state_in = ST_OUT1;
            end
         end
         ST_OUT1: begin
            if (out_free) begin
               state_in = has_r2_ff ? ST_OUT2 : ST_IDLE;
            end
         end
         ST_OUT2: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= RD_LEFT;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // arithmetic operands: row below is the arriving cell
   always_comb begin
      dp_op.ul  = ul_ff;
      dp_op.ur  = ur_ff;
      dp_op.uu  = uu_ff;
      dp_op.ud  = d_u_ff;
      dp_op.uc  = uc_ff;
      dp_op.du  = pdu_ff;
      dp_op.c   = pc_ff;
      dp_cfg.ts   = ts_ff;
      dp_cfg.its  = its_ff;
      dp_cfg.cs   = cs_ff;
      dp_cfg.damp = damp_ff;
   end

   wegs_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .start (dp_start),
      .op    (dp_op),
      .cfg   (dp_cfg),
      .done  (dp_done),
      .res   (dp_res)
   );

   // result register: border and last-row cells are zero cells
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      out_load  = out_free && ((state_ff == ST_OUT1) || (state_ff == ST_OUT2));
      out_in.u    = '0;
      out_in.du   = '0;
      out_in.c    = '0;
      out_in.gray = wegs_pkg::GRAY_ZERO;
      run_in      = 1'b1;
      frame_in    = 1'b0;
      if (state_ff == ST_OUT1) begin
         run_in = r1_run_ff;
         if (calc_ff) begin
            out_in = dp_res;
         end
      end else begin
         frame_in = r2_frame_ff;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff   <= out_in;
         run_ff   <= run_in;
         frame_ff <= frame_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_u         = out_ff.u;
   assign rsp_out_du        = out_ff.du;
   assign rsp_out_c         = out_ff.c;
   assign rsp_gray          = out_ff.gray;
   assign rsp_last_of_run   = run_ff;
   assign rsp_last_of_frame = frame_ff;

endmodule
